// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL of the rotation matrix block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// ===== src/eul2rm_pkg.sv =====
`timescale 1ns / 1ps
package eul2rm_pkg;
	// Series lengths of the sine and cosine expansions.
	localparam int SIN_TERMS = 8;
	localparam int COS_TERMS = 9;
	localparam int LANE_LAT = 4 + 3 * COS_TERMS + 1;
	localparam int MERGE_LAT = 5;
	localparam int NUM_ENT = 9;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam int RECIP_SHIFT = 33;

	// Term divisors (n+1)(n+2) and floor(2^33 / divisor).
	localparam logic [8:0] SIN_DIV [SIN_TERMS] = '{
		9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};
	localparam logic [32:0] SIN_RECIP [SIN_TERMS] = '{
		33'd1431655765, 33'd429496729, 33'd204522252, 33'd119304647,
		33'd78090314, 33'd55063683, 33'd40904450, 33'd31580641};
	localparam logic [8:0] COS_DIV [COS_TERMS] = '{
		9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306};
	localparam logic [32:0] COS_RECIP [COS_TERMS] = '{
		33'd4294967296, 33'd715827882, 33'd286331153, 33'd153391689,
		33'd95443717, 33'd65075262, 33'd47197442, 33'd35791394, 33'd28071681};

	typedef logic signed [31:0] trig_t;
	typedef logic [NUM_ENT-1:0][15:0] mat_t;
	typedef struct packed {
		logic en;
		logic neg;
	} lane_ctl_t;
	typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;
endpackage

// ===== src/eul2rm_trig.sv =====
`timescale 1ns / 1ps
module eul2rm_trig #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  eul2rm_pkg::lane_ctl_t ctl,
	input  logic [ANGLE_BITS-1:0] angle,
	output eul2rm_pkg::trig_t     sin_val,
	output eul2rm_pkg::trig_t     cos_val
);
	import eul2rm_pkg::*;

	localparam int RB = ANGLE_BITS - 2;
	localparam int PW = RB + 31;

	logic [ANGLE_BITS-1:0] phase_s1;
	quad_t quad_s2, quad_s3;
	logic [PW-1:0] rprod_s2;
	logic [PW-1:0] rsum;
	logic [30:0] x_s3;
	logic [61:0] xx;

	// Series state between term steps, index is the term count done.
	logic [31:0] ts_c [SIN_TERMS];
	logic [31:0] tc_c [COS_TERMS];
	logic [31:0] x2_c [COS_TERMS];
	logic signed [33:0] ss_c [COS_TERMS+1];
	logic signed [33:0] sc_c [COS_TERMS+1];
	quad_t q_c [COS_TERMS+1];

	logic [30:0] s_clamp, c_clamp;
	trig_t s_pos, c_pos;

	function automatic logic [30:0] clamp_unit(input logic signed [33:0] v);
		logic [30:0] r;
		if (v < 34'sd0) begin
			r = '0;
		end else if (v > $signed({2'b00, ONE_Q30})) begin
			r = ONE_Q30[30:0];
		end else begin
			r = v[30:0];
		end
		return r;
	endfunction

	assign rsum = rprod_s2 + (PW'(1) << (RB - 1));
	assign xx = 62'(x_s3) * 62'(x_s3);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			phase_s1 <= ctl.neg ? ({ANGLE_BITS{1'b0}} - angle) : angle;
			quad_s2 <= quad_t'(phase_s1[ANGLE_BITS-1 -: 2]);
			rprod_s2 <= PW'(phase_s1[RB-1:0]) * PW'(HALF_PI_Q30);
			quad_s3 <= quad_s2;
			x_s3 <= 31'(rsum >> RB);
			ts_c[0] <= {1'b0, x_s3};
			ss_c[0] <= $signed({3'b000, x_s3});
			tc_c[0] <= ONE_Q30;
			sc_c[0] <= $signed({2'b00, ONE_Q30});
			x2_c[0] <= 32'(xx >> 30);
			q_c[0] <= quad_s3;
		end
	end

	for (genvar k = 0; k < COS_TERMS; k++) begin : g_term
		localparam logic SUBTRACT = ((k % 2) == 0);
		logic [32:0] vc_a, vc_b, qc_b;
		logic signed [33:0] ss_a, sc_a, ss_b, sc_b;
		logic [31:0] x2_a, x2_b;
		quad_t q_a, q_b;
		logic [63:0] cprod;
		logic [65:0] cmul;
		logic [33:0] crem;
		logic [31:0] cterm;

		assign cprod = 64'(tc_c[k]) * 64'(x2_c[k]);
		assign cmul = 66'(vc_a) * 66'(COS_RECIP[k]);
		assign crem = {1'b0, vc_b} - 34'(42'(qc_b) * 42'(COS_DIV[k]));
		assign cterm = 32'(qc_b + 33'(crem >= 34'(COS_DIV[k])));

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				vc_a <= cprod[62:30];
				sc_a <= sc_c[k];
				ss_a <= ss_c[k];
				x2_a <= x2_c[k];
				q_a <= q_c[k];
				vc_b <= vc_a;
				qc_b <= 33'(cmul >> RECIP_SHIFT);
				sc_b <= sc_a;
				x2_b <= x2_a;
				q_b <= q_a;
				sc_c[k+1] <= SUBTRACT ? (sc_b - $signed({2'b00, cterm}))
				                      : (sc_b + $signed({2'b00, cterm}));
				q_c[k+1] <= q_b;
			end
		end

		if (k + 1 < COS_TERMS) begin : g_cnext
			always_ff @(posedge clk) begin
				if (ctl.en) begin
					tc_c[k+1] <= cterm;
					x2_c[k+1] <= x2_b;
				end
			end
		end

		if (k < SIN_TERMS) begin : g_sin
			logic [32:0] vs_a, vs_b, qs_b;
			logic [63:0] sprod;
			logic [65:0] smul;
			logic [33:0] srem;
			logic [31:0] sterm;

			assign sprod = 64'(ts_c[k]) * 64'(x2_c[k]);
			assign smul = 66'(vs_a) * 66'(SIN_RECIP[k]);
			assign srem = {1'b0, vs_b} - 34'(42'(qs_b) * 42'(SIN_DIV[k]));
			assign sterm = 32'(qs_b + 33'(srem >= 34'(SIN_DIV[k])));

			always_ff @(posedge clk) begin
				if (ctl.en) begin
					vs_a <= sprod[62:30];
					vs_b <= vs_a;
					qs_b <= 33'(smul >> RECIP_SHIFT);
					ss_b <= ss_a;
					ss_c[k+1] <= SUBTRACT ? (ss_b - $signed({2'b00, sterm}))
					                      : (ss_b + $signed({2'b00, sterm}));
				end
			end

			if (k + 1 < SIN_TERMS) begin : g_snext
				always_ff @(posedge clk) begin
					if (ctl.en) begin
						ts_c[k+1] <= sterm;
					end
				end
			end
		end else begin : g_sin_pass
			always_ff @(posedge clk) begin
				if (ctl.en) begin
					ss_b <= ss_a;
					ss_c[k+1] <= ss_b;
				end
			end
		end
	end

	assign s_clamp = clamp_unit(ss_c[COS_TERMS]);
	assign c_clamp = clamp_unit(sc_c[COS_TERMS]);
	assign s_pos = $signed({1'b0, s_clamp});
	assign c_pos = $signed({1'b0, c_clamp});

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			case (q_c[COS_TERMS])
				QUAD_0: begin
					sin_val <= s_pos;
					cos_val <= c_pos;
				end
				QUAD_1: begin
					sin_val <= c_pos;
					cos_val <= -s_pos;
				end
				QUAD_2: begin
					sin_val <= -s_pos;
					cos_val <= -c_pos;
				end
				default: begin
					sin_val <= -c_pos;
					cos_val <= s_pos;
				end
			endcase
		end
	end
endmodule

// ===== src/eul2rm_merge.sv =====
`timescale 1ns / 1ps
module eul2rm_merge #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic              clk,
	input  logic              en,
	input  eul2rm_pkg::trig_t sx,
	input  eul2rm_pkg::trig_t cx,
	input  eul2rm_pkg::trig_t sy,
	input  eul2rm_pkg::trig_t cy,
	input  eul2rm_pkg::trig_t sz,
	input  eul2rm_pkg::trig_t cz,
	output eul2rm_pkg::mat_t  mat
);
	import eul2rm_pkg::*;

	localparam int SH = 60 - COEF_FRAC_BITS;
	localparam logic signed [63:0] BIAS = 64'sd1 <<< (SH - 1);
	localparam logic signed [63:0] LIM = 64'sd1 <<< COEF_FRAC_BITS;
	localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

	logic signed [63:0] czsy_s1, szsy_s1;
	trig_t sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	trig_t czsy_s2, szsy_s2;
	trig_t sx_s2, cx_s2, sy_s2, cy_s2, sz_s2, cz_s2;
	logic signed [63:0] a_s3, b_s3, c_s3, d_s3;
	logic signed [63:0] czcy_s3, szcx_s3, szsx_s3, szcy_s3;
	logic signed [63:0] czcx_s3, czsx_s3, cysx_s3, cycx_s3;
	trig_t sy_s3;
	logic signed [63:0] v_s4 [NUM_ENT];

	function automatic logic [15:0] finish(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v + BIAS) >>> SH;
		if (r > LIM) begin
			r = LIM;
		end else if (r < -LIM) begin
			r = -LIM;
		end
		return r[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			czsy_s1 <= cz * sy;
			szsy_s1 <= sz * sy;
			sx_s1 <= sx;
			cx_s1 <= cx;
			sy_s1 <= sy;
			cy_s1 <= cy;
			sz_s1 <= sz;
			cz_s1 <= cz;

			// Round the shared partial products back to Q30.
			czsy_s2 <= 32'((czsy_s1 + HALF_Q30) >>> 30);
			szsy_s2 <= 32'((szsy_s1 + HALF_Q30) >>> 30);
			sx_s2 <= sx_s1;
			cx_s2 <= cx_s1;
			sy_s2 <= sy_s1;
			cy_s2 <= cy_s1;
			sz_s2 <= sz_s1;
			cz_s2 <= cz_s1;

			a_s3 <= czsy_s2 * sx_s2;
			b_s3 <= czsy_s2 * cx_s2;
			c_s3 <= szsy_s2 * sx_s2;
			d_s3 <= szsy_s2 * cx_s2;
			czcy_s3 <= cz_s2 * cy_s2;
			szcx_s3 <= sz_s2 * cx_s2;
			szsx_s3 <= sz_s2 * sx_s2;
			szcy_s3 <= sz_s2 * cy_s2;
			czcx_s3 <= cz_s2 * cx_s2;
			czsx_s3 <= cz_s2 * sx_s2;
			cysx_s3 <= cy_s2 * sx_s2;
			cycx_s3 <= cy_s2 * cx_s2;
			sy_s3 <= sy_s2;

			// Columns one and two carry the half-turn flip about x.
			v_s4[0] <= czcy_s3;
			v_s4[1] <= szcx_s3 - a_s3;
			v_s4[2] <= -(b_s3 + szsx_s3);
			v_s4[3] <= szcy_s3;
			v_s4[4] <= -(c_s3 + czcx_s3);
			v_s4[5] <= czsx_s3 - d_s3;
			v_s4[6] <= -(64'(sy_s3) <<< 30);
			v_s4[7] <= -cysx_s3;
			v_s4[8] <= -cycx_s3;

			for (int i = 0; i < NUM_ENT; i++) begin
				mat[i] <= finish(v_s4[i]);
			end
		end
	end
endmodule

// ===== src/euler_to_rotation_matrix.sv =====
// Throughput: one word per cycle while in_stall is low; three sine/cosine lanes and the product
// merge are fully pipelined, one series term every three stages.
// Reset: arst_n clears all valid state and sets negate_x_y_angles to one.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module euler_to_rotation_matrix #(
	parameter int ANGLE_BITS = 16,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] angle_x,
	input  logic signed [15:0] angle_y,
	input  logic signed [15:0] angle_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22
);
	import eul2rm_pkg::*;

	localparam int PIPE_LAT = LANE_LAT + MERGE_LAT;

	// Handedness register: when set, the x and y angles are negated on entry.
	logic negate_x_y_angles_q;

	// One valid bit per pipeline stage; the data path itself carries none.
	logic [PIPE_LAT-1:0] vld_q;
	logic advance;

	// Output register with a single skid word behind it, so the pipeline
	// stall comes from a flop and never from out_stall directly.
	logic out_valid_q, skid_full_q;
	mat_t out_mat_q, skid_mat_q;

	lane_ctl_t xy_ctl, z_ctl;
	logic [ANGLE_BITS-1:0] phase_x, phase_y, phase_z;
	trig_t sx, cx, sy, cy, sz, cz;
	mat_t pipe_mat;
	logic pipe_vld;

	// The pipeline moves whenever the skid word is free.
	assign advance = !skid_full_q;
	assign in_stall = skid_full_q;
	assign pipe_vld = vld_q[PIPE_LAT-1];

	// Angle bits above the phase width are ignored; a narrower port is
	// zero-extended.
	assign phase_x = ANGLE_BITS'($unsigned(angle_x));
	assign phase_y = ANGLE_BITS'($unsigned(angle_y));
	assign phase_z = ANGLE_BITS'($unsigned(angle_z));

	assign xy_ctl = '{en: advance, neg: negate_x_y_angles_q};
	assign z_ctl = '{en: advance, neg: 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			negate_x_y_angles_q <= 1'b1;
		end else if (cfg_wr_en) begin
			negate_x_y_angles_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_valid};
		end
	end

	// Three lanes of the same module, one for each axis; only the x and y lanes can negate their angle.
	eul2rm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_lane_x (
		.clk(clk), .ctl(xy_ctl), .angle(phase_x), .sin_val(sx), .cos_val(cx)
	);
	eul2rm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_lane_y (
		.clk(clk), .ctl(xy_ctl), .angle(phase_y), .sin_val(sy), .cos_val(cy)
	);
	eul2rm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_lane_z (
		.clk(clk), .ctl(z_ctl), .angle(phase_z), .sin_val(sz), .cos_val(cz)
	);

	// The merge stage combines the lane results into the nine entries.
	eul2rm_merge #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_merge (
		.clk(clk), .en(advance),
		.sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
		.mat(pipe_mat)
	);

	// Output control: an empty or departing output word is refilled from the
	// skid word first, otherwise from the pipeline. A word that arrives while
	// the output is held goes into the skid word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= advance && pipe_vld;
			end
		end else if (advance && pipe_vld) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_mat_q <= skid_full_q ? skid_mat_q : pipe_mat;
		end else if (advance && pipe_vld) begin
			skid_mat_q <= pipe_mat;
		end
	end

	assign out_valid = out_valid_q;
	assign m00 = $signed(out_mat_q[0]);
	assign m01 = $signed(out_mat_q[1]);
	assign m02 = $signed(out_mat_q[2]);
	assign m10 = $signed(out_mat_q[3]);
	assign m11 = $signed(out_mat_q[4]);
	assign m12 = $signed(out_mat_q[5]);
	assign m20 = $signed(out_mat_q[6]);
	assign m21 = $signed(out_mat_q[7]);
	assign m22 = $signed(out_mat_q[8]);

	// The skid word only ever sits behind a valid output word.
	`ASSERT_NEVER(a_skid_alone, clk, arst_n, skid_full_q && !out_valid_q)
	// The skid word fills only when the output word was held.
	`ASSERT_CLK(a_skid_fill, clk, arst_n, $rose(skid_full_q) |-> $past(out_valid_q && out_stall))
	// A full skid word moves into the output as soon as the output departs.
	`ASSERT_CLK(a_skid_drain, clk, arst_n, skid_full_q && !out_stall |=> out_valid_q && !skid_full_q)
endmodule
